// ----- hdl/cisq_pkg.sv -----
// Shared types, defaults and helpers for the case-insensitive string sorter.
package cisq_pkg;

	localparam int MAX_STRINGS_DEF  = 256;
	localparam int STRING_BYTES_DEF = 32;

	// Controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT,
		ST_POP,
		ST_POPRD,
		ST_SPLIT,
		ST_LOOP,
		ST_XRD,
		ST_XWR1,
		ST_XWR2,
		ST_CORD,
		ST_CLEN,
		ST_CRD,
		ST_CCHK,
		ST_CMP1,
		ST_CMP2,
		ST_PUSH1,
		ST_PUSH2,
		ST_FORD,
		ST_FLEN,
		ST_FRD,
		ST_FOUT
	} state_t;

	// Which pair of order positions the order-table ports address
	typedef enum logic [2:0] {
		PR_FETCH,
		PR_LO_MID,
		PR_LEFT_RIGHT,
		PR_LO_RIGHT,
		PR_LEFT_LO,
		PR_RIGHT_LO
	} pair_t;

	// Where an exchange returns to
	typedef enum logic [1:0] {
		XR_SPLIT,
		XR_SWAP,
		XR_PART
	} xret_t;

	// Which scan comparison is running
	typedef enum logic {
		CR_LEFT,
		CR_RIGHT
	} cret_t;

	typedef struct packed {
		pair_t pair;
		logic  load_step;
		logic  init_wr;
		logic  push_root;
		logic  sort_done;
		logic  pop_rd;
		logic  take_range;
		logic  ord_rd;
		logic  ord_wr_a;
		logic  ord_wr_b;
		logic  len_rd;
		logic  str_rd;
		logic  k_inc;
		logic  cmp_latch;
		logic  left_inc;
		logic  right_dec;
		logic  push_hi;
		logic  push_lo;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic phase_fetch;
		logic count_ok;
		logic n_small;
		logic init_last;
		logic stack_empty;
		logic range_empty;
		logic loop_done;
		logic cmp_end;
		logic cmp_lt;
		logic cmp_gt;
		logic can_push_hi;
		logic can_push_lo;
		logic out_busy;
	} sts_t;

	// Fold upper-case ASCII letters to lower case
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'd65 && c <= 8'd90) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

// ----- hdl/cisq_if.sv -----
// Valid/ready channel interfaces for input and result beats.
interface cisq_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] char_in;
	logic       string_end;
	logic       list_end;

	modport source(output valid, action, char_in, string_end, list_end, input ready);
	modport sink(input valid, action, char_in, string_end, list_end, output ready);
endinterface

interface cisq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       slot_last;
	logic       list_last;
	logic       overflow;

	modport source(output valid, char_out, slot_last, list_last, overflow, input ready);
	modport sink(input valid, char_out, slot_last, list_last, overflow, output ready);
endinterface

// ----- hdl/cisq_ctrl.sv -----
// Sequencer for loading, the quicksort walk and fetching.
module cisq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_action,
	input  logic          in_list_end,
	output logic          in_ready,
	output cisq_pkg::cmd_t cmd,
	input  cisq_pkg::sts_t sts
);
	import cisq_pkg::*;

	state_t state_q, state_d;
	xret_t  xret_q, xret_d;
	cret_t  cret_q, cret_d;
	logic   accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			xret_q  <= XR_SPLIT;
			cret_q  <= CR_LEFT;
		end else begin
			state_q <= state_d;
			xret_q  <= xret_d;
			cret_q  <= cret_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		xret_d  = xret_q;
		cret_d  = cret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!in_action && !sts.phase_fetch && in_list_end) begin
						state_d = ST_INIT;
					end else if (in_action && sts.phase_fetch && sts.count_ok) begin
						state_d = ST_FORD;
					end
				end
			end
			ST_INIT: begin
				if (sts.init_last) begin
					state_d = sts.n_small ? ST_IDLE : ST_POP;
				end
			end
			ST_POP:   state_d = sts.stack_empty ? ST_IDLE : ST_POPRD;
			ST_POPRD: state_d = ST_SPLIT;
			ST_SPLIT: begin
				if (sts.range_empty) begin
					state_d = ST_POP;
				end else begin
					xret_d  = XR_SPLIT;
					state_d = ST_XRD;
				end
			end
			ST_XRD:  state_d = ST_XWR1;
			ST_XWR1: state_d = ST_XWR2;
			ST_XWR2: state_d = (xret_q == XR_PART) ? ST_PUSH1 : ST_LOOP;
			ST_LOOP: begin
				if (sts.loop_done) begin
					xret_d  = XR_PART;
					state_d = ST_XRD;
				end else begin
					cret_d  = CR_LEFT;
					state_d = ST_CORD;
				end
			end
			ST_CORD: state_d = ST_CLEN;
			ST_CLEN: state_d = ST_CRD;
			ST_CRD:  state_d = ST_CCHK;
			ST_CCHK: begin
				if (sts.cmp_end) begin
					state_d = (cret_q == CR_LEFT) ? ST_CMP1 : ST_CMP2;
				end else begin
					state_d = ST_CRD;
				end
			end
			ST_CMP1: begin
				if (sts.cmp_lt) begin
					state_d = ST_LOOP;
				end else begin
					cret_d  = CR_RIGHT;
					state_d = ST_CORD;
				end
			end
			ST_CMP2: begin
				if (sts.cmp_gt) begin
					state_d = ST_LOOP;
				end else begin
					xret_d  = XR_SWAP;
					state_d = ST_XRD;
				end
			end
			ST_PUSH1: state_d = ST_PUSH2;
			ST_PUSH2: state_d = ST_POP;
			ST_FORD:  state_d = ST_FLEN;
			ST_FLEN:  state_d = ST_FRD;
			ST_FRD:   state_d = ST_FOUT;
			ST_FOUT:  state_d = sts.out_busy ? ST_FOUT : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = '0;
		cmd.pair = PR_FETCH;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_step = accept && !in_action && !sts.phase_fetch;
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					cmd.sort_done = sts.n_small;
					cmd.push_root = !sts.n_small;
				end
			end
			ST_POP: begin
				cmd.sort_done = sts.stack_empty;
				cmd.pop_rd    = !sts.stack_empty;
			end
			ST_POPRD: cmd.take_range = 1'b1;
			ST_XRD, ST_XWR1, ST_XWR2: begin
				case (xret_q)
					XR_SPLIT: cmd.pair = PR_LO_MID;
					XR_SWAP:  cmd.pair = PR_LEFT_RIGHT;
					default:  cmd.pair = PR_LO_RIGHT;
				endcase
				cmd.ord_rd   = (state_q == ST_XRD);
				cmd.ord_wr_a = (state_q == ST_XWR1);
				cmd.ord_wr_b = (state_q == ST_XWR2);
				if (state_q == ST_XWR2 && xret_q == XR_SWAP) begin
					cmd.left_inc  = 1'b1;
					cmd.right_dec = 1'b1;
				end
			end
			ST_CORD, ST_CLEN, ST_CRD, ST_CCHK: begin
				cmd.pair      = (cret_q == CR_LEFT) ? PR_LEFT_LO : PR_RIGHT_LO;
				cmd.ord_rd    = (state_q == ST_CORD);
				cmd.len_rd    = (state_q == ST_CLEN);
				cmd.str_rd    = (state_q == ST_CRD);
				cmd.cmp_latch = (state_q == ST_CCHK);
				cmd.k_inc     = (state_q == ST_CCHK) && !sts.cmp_end;
			end
			ST_CMP1:  cmd.left_inc  = sts.cmp_lt;
			ST_CMP2:  cmd.right_dec = sts.cmp_gt;
			ST_PUSH1: cmd.push_hi   = sts.can_push_hi;
			ST_PUSH2: cmd.push_lo   = sts.can_push_lo;
			ST_FORD:  cmd.ord_rd    = 1'b1;
			ST_FLEN:  cmd.len_rd    = 1'b1;
			ST_FRD:   cmd.str_rd    = 1'b1;
			ST_FOUT:  cmd.out_load  = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ----- hdl/cisq_dp.sv -----
// Datapath: string store, lengths, order table, range stack and output register.
module cisq_dp #(
	parameter int MAX_STRINGS  = cisq_pkg::MAX_STRINGS_DEF,
	parameter int STRING_BYTES = cisq_pkg::STRING_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cisq_pkg::cmd_t cmd,
	output cisq_pkg::sts_t sts,
	input  logic [7:0]     char_in,
	input  logic           string_end,
	input  logic           list_end,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [7:0]     char_out,
	output logic           slot_last,
	output logic           list_last,
	output logic           overflow
);
	import cisq_pkg::*;

	localparam int IW  = $clog2(MAX_STRINGS);
	localparam int PW1 = IW + 1;
	localparam int CW  = $clog2(MAX_STRINGS + 1);
	localparam int LW  = $clog2(STRING_BYTES + 1);
	localparam int OW  = $clog2(STRING_BYTES);
	localparam int AW  = $clog2(MAX_STRINGS * STRING_BYTES);
	localparam int DEPTH = MAX_STRINGS * STRING_BYTES;

	// Memories
	logic [7:0]      store_mem [DEPTH];
	logic [LW-1:0]   len_mem   [MAX_STRINGS];
	logic [IW-1:0]   ord_mem   [MAX_STRINGS];
	logic [2*IW-1:0] stk_mem   [MAX_STRINGS];

	// Control registers
	logic [CW-1:0] count_q, i_q, top_q;
	logic [LW-1:0] pos_q;
	logic          term_q, ovf_q, phase_q;
	logic [IW-1:0] idx_q;
	logic [OW-1:0] off_q;
	logic          out_valid_q;

	// Payload registers
	logic [PW1-1:0] lo_q, hi_q, left_q, right_q;
	logic [OW-1:0]  k_q;
	logic [AW-1:0]  base_a_q, base_b_q;
	logic           cmp_lt_q, cmp_gt_q;
	logic [7:0]     str_a_q, str_b_q;
	logic [LW-1:0]  len_a_q, len_b_q;
	logic [IW-1:0]  ord_a_q, ord_b_q;
	logic [2*IW-1:0] stk_q;
	logic [7:0]     char_out_q;
	logic           slot_last_q, list_last_q, overflow_q;

	// Combinational helpers
	logic           slot_ok, byte_wr, len_wr;
	logic [LW-1:0]  len_wdata;
	logic [AW-1:0]  store_waddr, store_raddr_a, store_raddr_b;
	logic [PW1-1:0] mid, addr_a, addr_b;
	logic [CW-1:0]  count_m1;
	logic [7:0]     ch_a, ch_b, fa, fb;
	logic           neq;
	logic [IW-1:0]  stk_waddr;
	logic [2*IW-1:0] stk_wdata;
	logic           stk_wr;
	logic [CW-1:0]  top_m1;
	logic           f_slot_last, f_list_last;
	logic [7:0]     f_char;

	function automatic logic [IW-1:0] right_p1_slice();
		logic [PW1-1:0] v;
		v = right_q + PW1'(1);
		return v[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] right_m1_slice();
		logic [PW1-1:0] v;
		v = right_q - PW1'(1);
		return v[IW-1:0];
	endfunction

	assign count_m1 = count_q - CW'(1);
	assign top_m1   = top_q - CW'(1);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	// Order-table port addresses for the current pair
	always_comb begin
		case (cmd.pair)
			PR_LO_MID:     begin addr_a = lo_q;   addr_b = mid;   end
			PR_LEFT_RIGHT: begin addr_a = left_q; addr_b = right_q; end
			PR_LO_RIGHT:   begin addr_a = lo_q;   addr_b = right_q; end
			PR_LEFT_LO:    begin addr_a = left_q; addr_b = lo_q;  end
			PR_RIGHT_LO:   begin addr_a = right_q; addr_b = lo_q; end
			default:       begin addr_a = {1'b0, idx_q}; addr_b = {1'b0, idx_q}; end
		endcase
	end

	// Load beat decode
	assign slot_ok     = count_q < CW'(MAX_STRINGS);
	assign len_wr      = cmd.load_step && slot_ok && !term_q;
	assign byte_wr     = len_wr && (char_in != 8'd0) && (pos_q < LW'(STRING_BYTES));
	assign len_wdata   = byte_wr ? pos_q + LW'(1) : pos_q;
	assign store_waddr = AW'(count_q[IW-1:0]) * AW'(STRING_BYTES) + AW'(pos_q);

	// Store read addresses: fetch walks the slot offset, compare walks k
	assign store_raddr_a = base_a_q + ((cmd.pair == PR_FETCH) ? AW'(off_q) : AW'(k_q));
	assign store_raddr_b = base_b_q + AW'(k_q);

	// Byte compare, bytes past the stored length read as zero
	assign ch_a = (LW'(k_q) < len_a_q) ? str_a_q : 8'd0;
	assign ch_b = (LW'(k_q) < len_b_q) ? str_b_q : 8'd0;
	assign fa   = fold(ch_a);
	assign fb   = fold(ch_b);
	assign neq  = (fa != fb);

	// Stack write port
	always_comb begin
		stk_wr    = cmd.push_root || cmd.push_hi || cmd.push_lo;
		stk_waddr = top_q[IW-1:0];
		stk_wdata = {lo_q[IW-1:0], right_m1_slice()};
		if (cmd.push_root) begin
			stk_waddr = '0;
			stk_wdata = {IW'(0), count_m1[IW-1:0]};
		end else if (cmd.push_hi) begin
			stk_wdata = {right_p1_slice(), hi_q[IW-1:0]};
		end
	end

	// Fetch byte
	assign f_char      = (LW'(off_q) < len_a_q) ? str_a_q : 8'd0;
	assign f_slot_last = (off_q == OW'(STRING_BYTES - 1));
	assign f_list_last = f_slot_last && (CW'(idx_q) == count_m1);

	// Status to the controller
	assign sts.phase_fetch = phase_q;
	assign sts.count_ok    = (count_q != '0);
	assign sts.n_small     = (count_q < CW'(2));
	assign sts.init_last   = (i_q == count_m1);
	assign sts.stack_empty = (top_q == '0);
	assign sts.range_empty = (lo_q >= hi_q);
	assign sts.loop_done   = (left_q > right_q);
	assign sts.cmp_end     = neq || (fa == 8'd0) || (k_q == OW'(STRING_BYTES - 1));
	assign sts.cmp_lt      = cmp_lt_q;
	assign sts.cmp_gt      = cmp_gt_q;
	assign sts.can_push_hi = ((right_q + PW1'(1)) < hi_q) && (top_q < CW'(MAX_STRINGS));
	assign sts.can_push_lo = ((lo_q + PW1'(1)) < right_q) && (top_q < CW'(MAX_STRINGS));
	assign sts.out_busy    = out_valid_q && !out_ready;

	// String store
	always_ff @(posedge clk) begin
		if (byte_wr) begin
			store_mem[store_waddr] <= char_in;
		end
		if (cmd.str_rd) begin
			str_a_q <= store_mem[store_raddr_a];
			str_b_q <= store_mem[store_raddr_b];
		end
	end

	// Slot lengths
	always_ff @(posedge clk) begin
		if (len_wr) begin
			len_mem[count_q[IW-1:0]] <= len_wdata;
		end
		if (cmd.len_rd) begin
			len_a_q <= len_mem[ord_a_q];
			len_b_q <= len_mem[ord_b_q];
		end
	end

	// Order table
	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			ord_mem[i_q[IW-1:0]] <= i_q[IW-1:0];
		end else if (cmd.ord_wr_a) begin
			ord_mem[addr_a[IW-1:0]] <= ord_b_q;
		end else if (cmd.ord_wr_b) begin
			ord_mem[addr_b[IW-1:0]] <= ord_a_q;
		end
		if (cmd.ord_rd) begin
			ord_a_q <= ord_mem[addr_a[IW-1:0]];
			ord_b_q <= ord_mem[addr_b[IW-1:0]];
		end
	end

	// Range stack
	always_ff @(posedge clk) begin
		if (stk_wr) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (cmd.pop_rd) begin
			stk_q <= stk_mem[top_m1[IW-1:0]];
		end
	end

	// Partition, compare and output payload registers
	always_ff @(posedge clk) begin
		if (cmd.take_range) begin
			lo_q    <= {1'b0, stk_q[2*IW-1:IW]};
			hi_q    <= {1'b0, stk_q[IW-1:0]};
			left_q  <= {1'b0, stk_q[2*IW-1:IW]} + PW1'(1);
			right_q <= {1'b0, stk_q[IW-1:0]};
		end else begin
			if (cmd.left_inc) begin
				left_q <= left_q + PW1'(1);
			end
			if (cmd.right_dec) begin
				right_q <= right_q - PW1'(1);
			end
		end
		if (cmd.len_rd) begin
			base_a_q <= AW'(ord_a_q) * AW'(STRING_BYTES);
			base_b_q <= AW'(ord_b_q) * AW'(STRING_BYTES);
			k_q      <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + OW'(1);
		end
		if (cmd.cmp_latch) begin
			cmp_lt_q <= neq && (fa < fb);
			cmp_gt_q <= neq && (fa > fb);
		end
		if (cmd.out_load) begin
			char_out_q  <= f_char;
			slot_last_q <= f_slot_last;
			list_last_q <= f_list_last;
			overflow_q  <= ovf_q;
		end
	end

	// Load, sort and fetch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			term_q      <= 1'b0;
			ovf_q       <= 1'b0;
			phase_q     <= 1'b0;
			i_q         <= '0;
			top_q       <= '0;
			idx_q       <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_step) begin
				i_q <= '0;
				// Dropped string, or a byte beyond the slot length
				if (!slot_ok || (len_wr && (char_in != 8'd0) &&
						(pos_q >= LW'(STRING_BYTES)))) begin
					ovf_q <= 1'b1;
				end
				if (string_end || list_end) begin
					if (slot_ok) begin
						count_q <= count_q + CW'(1);
					end
					pos_q  <= '0;
					term_q <= 1'b0;
				end else if (len_wr) begin
					if (char_in == 8'd0) begin
						term_q <= 1'b1;
					end else if (byte_wr) begin
						pos_q <= pos_q + LW'(1);
					end
				end
			end
			if (cmd.init_wr) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.push_root) begin
				top_q <= CW'(1);
			end else if (cmd.pop_rd) begin
				top_q <= top_m1;
			end else if (cmd.push_hi || cmd.push_lo) begin
				top_q <= top_q + CW'(1);
			end
			if (cmd.sort_done) begin
				phase_q <= 1'b1;
				idx_q   <= '0;
				off_q   <= '0;
			end
			// Output register and read position
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (f_list_last) begin
					phase_q <= 1'b0;
					count_q <= '0;
					pos_q   <= '0;
					idx_q   <= '0;
					off_q   <= '0;
					ovf_q   <= 1'b0;
					term_q  <= 1'b0;
				end else if (f_slot_last) begin
					off_q <= '0;
					idx_q <= idx_q + IW'(1);
				end else begin
					off_q <= off_q + OW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_out_q;
	assign slot_last = slot_last_q;
	assign list_last = list_last_q;
	assign overflow  = overflow_q;

endmodule

// ----- hdl/case_insensitive_string_quicksort.sv -----
// Top level of the case-insensitive string quicksort block.
//
//   channel     | role    | beat contents
//   ------------+---------+---------------------------------------------
//   item_in     | sink    | action, char_in, string_end, list_end
//   result_out  | source  | char_out, slot_last, list_last, overflow
//
// A fetch beat passes through accept, order table, slot length, string store
// and output register, and waits while the output register is still held by
// the sink. The list_end load starts the sort: the order table is seeded, then
// each partition runs exchanges (a read, then two writes) and string compares
// (order read, length read, then a store read and check per byte), all set by
// the single-port-write order table and the dual-read string store.
// Reset clears only control state; no memory needs a clearing pass.
module case_insensitive_string_quicksort #(
	parameter int MAX_STRINGS  = cisq_pkg::MAX_STRINGS_DEF,
	parameter int STRING_BYTES = cisq_pkg::STRING_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cisq_in_if.sink    item_in,
	cisq_out_if.source result_out
);
	import cisq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	cisq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item_in.valid),
		.in_action  (item_in.action),
		.in_list_end(item_in.list_end),
		.in_ready   (item_in.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Storage and arithmetic
	cisq_dp #(
		.MAX_STRINGS (MAX_STRINGS),
		.STRING_BYTES(STRING_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.char_in   (item_in.char_in),
		.string_end(item_in.string_end),
		.list_end  (item_in.list_end),
		.out_ready (result_out.ready),
		.out_valid (result_out.valid),
		.char_out  (result_out.char_out),
		.slot_last (result_out.slot_last),
		.list_last (result_out.list_last),
		.overflow  (result_out.overflow)
	);

endmodule

// ----- hdl/cisq_chk.sv -----
// Port-level checker for the string sorter, bound to the top level.
module cisq_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_action,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_slot_last,
	input logic       out_list_last,
	input logic       out_overflow
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({out_char, out_slot_last, out_list_last, out_overflow}))
		else $error("result beat changed while stalled");

	// A fresh result follows a fetch beat through the order, length, store and output steps
	a_fetch_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_action, 5))
		else $error("result without a fetch beat five edges earlier");

	// Input side is closed while a fetch is in flight
	a_busy_on_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready, 1) && !$past(in_ready, 2) &&
		!$past(in_ready, 3) && !$past(in_ready, 4))
		else $error("input accepted during a fetch");

endmodule

bind case_insensitive_string_quicksort cisq_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item_in.valid),
	.in_ready     (item_in.ready),
	.in_action    (item_in.action),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.out_char     (result_out.char_out),
	.out_slot_last(result_out.slot_last),
	.out_list_last(result_out.list_last),
	.out_overflow (result_out.overflow)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the case-insensitive string quicksort block.
`timescale 1ns / 1ps

module testbench;
	import cisq_pkg::*;

	localparam int NSLOT = MAX_STRINGS_DEF;
	localparam int SLEN  = STRING_BYTES_DEF;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	typedef enum logic [1:0] {SORT_LOADING, SORT_FETCHING} sort_phase_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       slot_last;
		logic       list_last;
		logic       overflow;
	} sorted_byte_t;

	logic clk;
	logic arst_n;

	cisq_in_if  item_in ();
	cisq_out_if result_out ();

	case_insensitive_string_quicksort i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out)
	);

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Shadow copy of the sorter state
	logic [7:0]  shadow_store [NSLOT][SLEN];
	logic [8:0]  shadow_order [NSLOT];
	logic [8:0]  shadow_count;
	logic [12:0] shadow_bpos;
	logic [12:0] shadow_rpos;
	sort_phase_t shadow_phase;
	logic        shadow_ovf;
	logic        shadow_term;

	sorted_byte_t expected_bytes [$];
	int  fail_count;
	bit  idle_on;
	bit  hold_req;
	int  hold_cnt;
	int  rx_wait;
	int  beats_sent;

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// Sign of the folded comparison of the slots at order positions a and b
	function automatic int compare_slots(input int a, input int b);
		logic [7:0] ca, cb;
		for (int k = 0; k < SLEN; k++) begin
			ca = lower(shadow_store[shadow_order[a]][k]);
			cb = lower(shadow_store[shadow_order[b]][k]);
			if (ca != cb) return (ca < cb) ? -1 : 1;
			if (ca == 8'd0) return 0;
		end
		return 0;
	endfunction

	function automatic void swap_order(input int a, input int b);
		logic [8:0] t;
		t = shadow_order[a];
		shadow_order[a] = shadow_order[b];
		shadow_order[b] = t;
	endfunction

	function automatic int partition(input int lo, input int hi);
		int l, r;
		l = lo + 1;
		r = hi;
		swap_order(lo, lo + (hi - lo) / 2);
		while (l <= r) begin
			if (compare_slots(l, lo) < 0) l++;
			else if (compare_slots(r, lo) > 0) r--;
			else begin
				swap_order(l, r);
				l++;
				r--;
			end
		end
		swap_order(lo, r);
		return r;
	endfunction

	function automatic void sort_shadow(input int n);
		int stk_lo [$];
		int stk_hi [$];
		int lo, hi, p;
		for (int i = 0; i < n; i++) shadow_order[i] = i[8:0];
		if (n < 2) return;
		stk_lo.push_back(0);
		stk_hi.push_back(n - 1);
		while (stk_lo.size() > 0) begin
			lo = stk_lo.pop_back();
			hi = stk_hi.pop_back();
			if (lo >= hi) continue;
			p = partition(lo, hi);
			if (p + 1 < hi) begin
				stk_lo.push_back(p + 1);
				stk_hi.push_back(hi);
			end
			if (lo < p - 1) begin
				stk_lo.push_back(lo);
				stk_hi.push_back(p - 1);
			end
		end
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < NSLOT; i++) shadow_order[i] = i[8:0];
		shadow_count = '0;
		shadow_bpos  = '0;
		shadow_rpos  = '0;
		shadow_phase = SORT_LOADING;
		shadow_ovf   = 1'b0;
		shadow_term  = 1'b0;
	endfunction

	// Advance the shadow state by one accepted beat
	function automatic void predict_beat(input logic act, input logic [7:0] c,
			input logic s_end, input logic l_end);
		int idx, off, phys;
		sorted_byte_t e;
		if (act == ACT_LOAD) begin
			if (shadow_phase != SORT_LOADING) return;
			if (shadow_count < NSLOT) begin
				if (shadow_bpos == 0 && !shadow_term)
					for (int k = 0; k < SLEN; k++) shadow_store[shadow_count][k] = 8'd0;
				if (!shadow_term) begin
					if (c == 8'd0) shadow_term = 1'b1;
					else if (shadow_bpos < SLEN) begin
						shadow_store[shadow_count][shadow_bpos] = c;
						shadow_bpos++;
					end else shadow_ovf = 1'b1;
				end
			end else shadow_ovf = 1'b1;
			if (s_end || l_end) begin
				if (shadow_count < NSLOT) shadow_count++;
				shadow_bpos = '0;
				shadow_term = 1'b0;
			end
			if (l_end) begin
				sort_shadow(shadow_count);
				shadow_phase = SORT_FETCHING;
				shadow_rpos  = '0;
			end
			return;
		end
		if (shadow_phase != SORT_FETCHING || shadow_count == 0) return;
		idx = shadow_rpos / SLEN;
		off = shadow_rpos % SLEN;
		if (idx >= shadow_count) idx = shadow_count - 1;
		phys = shadow_order[idx];
		e.char_out  = shadow_store[phys][off];
		e.slot_last = (off == SLEN - 1);
		e.list_last = e.slot_last && (idx == shadow_count - 1);
		e.overflow  = shadow_ovf;
		expected_bytes.push_back(e);
		shadow_rpos++;
		if (shadow_rpos >= shadow_count * SLEN || e.list_last) begin
			shadow_phase = SORT_LOADING;
			shadow_count = '0;
			shadow_bpos  = '0;
			shadow_rpos  = '0;
			shadow_ovf   = 1'b0;
			shadow_term  = 1'b0;
		end
	endfunction

	// Send one beat, after a random gap when idle_on is set, then update the shadow state
	task automatic send_beat(input logic act, input logic [7:0] c,
			input logic s_end, input logic l_end);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_in.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		item_in.valid      <= 1'b1;
		item_in.action     <= act;
		item_in.char_in    <= c;
		item_in.string_end <= s_end;
		item_in.list_end   <= l_end;
		do @(posedge clk); while (!item_in.ready);
		predict_beat(act, c, s_end, l_end);
		beats_sent++;
	endtask

	task automatic load_text(input string s, input bit last);
		for (int i = 0; i < s.len(); i++)
			send_beat(ACT_LOAD, s[i], i == s.len() - 1, last && i == s.len() - 1);
	endtask

	task automatic drain_list();
		while (shadow_phase == SORT_FETCHING)
			send_beat(ACT_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
	endtask

	// Receiver: random stalls per beat, plus a long hold when asked
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_out.ready <= 1'b0;
			hold_cnt = 0;
		end else begin
			if (hold_req) begin
				hold_cnt = 300;
				hold_req = 1'b0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_out.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		sorted_byte_t e;
		if (arst_n && result_out.valid && result_out.ready) begin
			rx_wait = idle_on ? $urandom_range(0, 16) : 0;
			if (expected_bytes.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = expected_bytes.pop_front();
				if (result_out.char_out !== e.char_out) begin
					$error("char_out expected %0h got %0h", e.char_out, result_out.char_out);
					fail_count++;
				end
				if (result_out.slot_last !== e.slot_last) begin
					$error("slot_last expected %0b got %0b", e.slot_last, result_out.slot_last);
					fail_count++;
				end
				if (result_out.list_last !== e.list_last) begin
					$error("list_last expected %0b got %0b", e.list_last, result_out.list_last);
					fail_count++;
				end
				if (result_out.overflow !== e.overflow) begin
					$error("overflow expected %0b got %0b", e.overflow, result_out.overflow);
					fail_count++;
				end
			end
		end
	end

	// Folding, equal-apart-from-case ordering and byte extremes
	task automatic test_case_fold();
		load_text("abc", 0);
		load_text("ABC", 0);
		load_text("AbD", 0);
		load_text("@[`{", 0);
		send_beat(ACT_LOAD, 8'hFF, 1'b0, 1'b0);
		send_beat(ACT_LOAD, 8'h01, 1'b1, 1'b0);
		load_text("zZ", 1);
		drain_list();
	endtask

	// Over-long string, bytes after a zero, list_end without string_end
	task automatic test_long_and_zero();
		for (int i = 0; i < SLEN + 2; i++)
			send_beat(ACT_LOAD, 8'("a" + (i % 26)), 1'b0, 1'b0);
		send_beat(ACT_LOAD, "q", 1'b1, 1'b0);
		send_beat(ACT_LOAD, "x", 1'b0, 1'b0);
		send_beat(ACT_LOAD, 8'h00, 1'b0, 1'b0);
		send_beat(ACT_LOAD, "b", 1'b0, 1'b0);
		send_beat(ACT_LOAD, 8'h00, 1'b0, 1'b1);
		drain_list();
	endtask

	// Fetch while loading and load while fetching are ignored; single string
	task automatic test_ignored_beats();
		send_beat(ACT_FETCH, 8'hA5, 1'b1, 1'b1);
		load_text("Solo", 1);
		send_beat(ACT_LOAD, 8'h5A, 1'b1, 1'b1);
		drain_list();
	endtask

	// One string beyond capacity is dropped and flagged
	task automatic test_capacity();
		idle_on = 1'b0;
		for (int i = 0; i <= NSLOT; i++)
			send_beat(ACT_LOAD, 8'($urandom_range(33, 126)), 1'b1, i == NSLOT);
		drain_list();
		idle_on = 1'b1;
	endtask

	// Long receiver hold while fetches queue up, then a sender pause
	task automatic test_pressure();
		load_text("delta", 0);
		load_text("Alpha", 0);
		load_text("charlie", 1);
		hold_req = 1'b1;
		drain_list();
		@(negedge clk);
		item_in.valid <= 1'b0;
		wait (expected_bytes.size() == 0);
	endtask

	// Random lists, mostly well formed, with noise beats mixed in
	task automatic test_random();
		int nstr, nb, start;
		logic [7:0] c;
		start = beats_sent;
		while (beats_sent - start < 400) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 5) == 0)
				send_beat(ACT_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			nstr = $urandom_range(1, 5);
			for (int s = 0; s < nstr; s++) begin
				nb = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
				for (int b = 0; b < nb; b++) begin
					case ($urandom_range(0, 9))
						0: c = 8'($urandom_range(0, 255));
						1: c = 8'h00;
						2, 3, 4: c = 8'($urandom_range("A", "C"));
						default: c = 8'($urandom_range("a", "c"));
					endcase
					send_beat(ACT_LOAD, c, b == nb - 1,
						(s == nstr - 1) && (b == nb - 1));
				end
			end
			if ($urandom_range(0, 3) == 0)
				send_beat(ACT_LOAD, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
			drain_list();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		fail_count = 0;
		beats_sent = 0;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		rx_wait    = 0;
		item_in.valid      = 1'b0;
		item_in.action     = ACT_LOAD;
		item_in.char_in    = 8'd0;
		item_in.string_end = 1'b0;
		item_in.list_end   = 1'b0;
		shadow_reset();
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_case_fold();
		test_long_and_zero();
		test_ignored_beats();
		test_pressure();
		test_capacity();
		test_random();

		@(negedge clk);
		item_in.valid <= 1'b0;
		wait (expected_bytes.size() == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- case_insensitive_string_quicksort.f -----
hdl/cisq_pkg.sv
hdl/cisq_if.sv
hdl/cisq_ctrl.sv
hdl/cisq_dp.sv
hdl/case_insensitive_string_quicksort.sv
hdl/cisq_chk.sv
test/testbench.sv
